@@ sv/arx_model_step_with_coef_ramp_macros.svh @@
// Assertion macros shared by the ARX model RTL.
`ifndef ARX_MODEL_STEP_WITH_COEF_RAMP_MACROS_SVH
`define ARX_MODEL_STEP_WITH_COEF_RAMP_MACROS_SVH
`ifndef SYNTH
`define ARXM_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ARX model: same-cycle check failed");
`define ARXM_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ARX model: next-cycle check failed");
`else
`define ARXM_AST_IMP(lbl, clk, rstn, ante, cons)
`define ARXM_AST_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/arxm_pkg.sv @@
// Types and codes shared by the ARX model block.
`timescale 1ns / 1ps
package arxm_pkg;

    typedef enum logic [2:0] {
        CMD_STEP        = 3'd0,
        CMD_LOAD_START  = 3'd1,
        CMD_LOAD_TARGET = 3'd2,
        CMD_RAMP        = 3'd3,
        CMD_RESTORE     = 3'd4
    } t_cmd;

    localparam logic [2:0] CFG_DELAY_K     = 3'd0;
    localparam logic [2:0] CFG_ORDER_A     = 3'd1;
    localparam logic [2:0] CFG_ORDER_B     = 3'd2;
    localparam logic [2:0] CFG_RAMP_PERIOD = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_DRAIN,
        S_OUT,
        S_DIVRD,
        S_DIV,
        S_SWEEP,
        S_SWEND
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] sample_in;
        logic signed [31:0] noise_in;
        logic               coef_bank;
        logic [2:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] y_out;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  idx;
        logic [15:0] data;
    } t_cfg_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ sv/arxm_stream_if.sv @@
// Valid/ready channel carrying one payload type.
`timescale 1ns / 1ps
interface arxm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/arxm_div.sv @@
// Bit-serial signed divide of a coefficient difference by the ramp period.
`timescale 1ns / 1ps
module arxm_div
    import arxm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_diff,
    input  logic [15:0]        i_period,
    output t_div_stat          o_stat,
    output logic signed [31:0] o_q
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [31:0] r_quo;
    logic        r_neg;
    logic [15:0] r_d;
    logic [16:0] w_trial;
    logic [32:0] w_neg_diff;

    assign w_trial    = {r_rem[15:0], r_quo[31]};
    assign w_neg_diff = -i_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_diff[32];
            r_quo <= i_diff[32] ? w_neg_diff[31:0] : i_diff[31:0];
            r_rem <= '0;
            r_cnt <= '0;
            r_d   <= i_period;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (w_trial >= {1'b0, r_d}) begin
                r_rem <= w_trial - {1'b0, r_d};
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // Truncation toward zero comes from dividing the magnitude.
    always_comb begin
        if (r_neg) begin
            o_q = (r_quo > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(r_quo);
        end else begin
            o_q = r_quo[31] ? 32'sh7fff_ffff : $signed(r_quo);
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
endmodule

@@ sv/arx_model_step_with_coef_ramp.sv @@
// Top level of the ARX process model with coefficient ramping.
//
//  channel  | dir | payload
//  i_in     | in  | cmd, sample_in, noise_in, coef_bank, coef_index, coef_value
//  o_out    | out | y_out, saturated
//  i_cfg    | in  | register index, write data
//
// A step request: one shared multiplier walks the B then A taps, one tap a cycle
// from the coefficient and history memories, then the rounded sum is registered.
// A target load runs 32 iterations of the bit-serial divider; ramp and restore
// sweep all NA_MAX + NB_MAX coefficients, one a cycle. Start loads and unknown
// requests stay idle.
// Reset clears the delay lines and coefficients through per-entry valid bits, so no
// clearing pass is needed. A held result stalls the step only when a second one is due.
`timescale 1ns / 1ps
`include "arx_model_step_with_coef_ramp_macros.svh"
module arx_model_step_with_coef_ramp
    import arxm_pkg::*;
#(
    parameter int NA_MAX    = 8,
    parameter int NB_MAX    = 8,
    parameter int MAX_DELAY = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    arxm_stream_if.sink   i_in,
    arxm_stream_if.source o_out,
    arxm_stream_if.sink   i_cfg
);
    localparam int UH = MAX_DELAY + NB_MAX;
    localparam int NC = NA_MAX + NB_MAX;
    localparam int UW = (UH > 1) ? $clog2(UH) : 1;
    localparam int YW = (NA_MAX > 1) ? $clog2(NA_MAX) : 1;
    localparam int CW = $clog2(NC);
    localparam int TW = CW + 1;

    t_state r_state, n_state;

    logic [4:0]  r_delay_k;
    logic [3:0]  r_order_a;
    logic [2:0]  r_order_b;
    logic [15:0] r_ramp_period;

    logic [CW-1:0] r_cnt;
    logic          r_ph_a;
    logic [UW-1:0] r_uwp;
    logic [YW-1:0] r_ywp;
    logic signed [63:0] r_acc;
    logic          r_p1_v, r_p1_neg, r_p2_v, r_p2_neg;
    logic signed [63:0] r_prod;
    logic          r_sw_v, r_sw_ramp;
    logic [CW-1:0] r_sw_a;
    logic signed [31:0] r_cval;
    logic [CW-1:0] r_ca;
    logic          r_ovalid;
    t_out_item     r_odata;

    // Memories and their valid bits.
    logic signed [31:0] m_act [NC];
    logic signed [31:0] m_st  [NC];
    logic signed [31:0] m_dl  [NC];
    logic signed [31:0] m_uh  [UH];
    logic signed [31:0] m_yh  [NA_MAX];
    logic [NC-1:0]     r_act_v, r_st_v, r_dl_v;
    logic [UH-1:0]     r_uh_v;
    logic [NA_MAX-1:0] r_yh_v;
    logic signed [31:0] r_act_q, r_st_q, r_dl_q, r_uh_q, r_yh_q;
    logic r_act_qv, r_st_qv, r_dl_qv, r_uh_qv, r_yh_qv;
    logic signed [31:0] w_act_val, w_st_val, w_dl_val, w_uh_val, w_yh_val;

    logic [CW-1:0] w_c_ra, w_in_ca, w_act_wa;
    logic [UW-1:0] w_uh_ra;
    logic [YW-1:0] w_yh_ra;
    logic          w_act_we;
    logic signed [31:0] w_act_wd;
    logic          w_in_ok, w_in_fire, w_cfg_fire, w_out_load, w_tap_last;
    logic [UW:0]   w_k;
    logic [TW-1:0] w_na, w_nb;
    logic [UW+1:0] w_upos, w_usum;
    logic [YW:0]   w_ysum;
    logic signed [63:0] w_rnd, w_sh, w_term;
    logic          w_ovf;
    logic signed [31:0] w_y;
    logic signed [32:0] w_rsum;
    logic signed [31:0] w_rsat;
    logic          w_div_start;
    logic signed [32:0] w_div_diff;
    logic [15:0]   w_period;
    t_div_stat     w_div_stat;
    logic signed [31:0] w_div_q;
    t_in_item      w_in;

    assign w_in       = i_in.data;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_k     <= 5'd0;
            r_order_a     <= 4'd1;
            r_order_b     <= 3'd0;
            r_ramp_period <= 16'd1;
        end else if (w_cfg_fire) begin
            case (i_cfg.data.idx)
                CFG_DELAY_K:     r_delay_k     <= i_cfg.data.data[4:0];
                CFG_ORDER_A:     r_order_a     <= i_cfg.data.data[3:0];
                CFG_ORDER_B:     r_order_b     <= i_cfg.data.data[2:0];
                CFG_RAMP_PERIOD: r_ramp_period <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    // Clamped tap counts and delay.
    always_comb begin
        w_k  = (32'(r_delay_k) > MAX_DELAY) ? (UW+1)'(MAX_DELAY) : (UW+1)'(r_delay_k);
        w_na = (32'(r_order_a) > NA_MAX) ? TW'(NA_MAX) : TW'(r_order_a);
        w_nb = (32'(r_order_b) + 1 > NB_MAX) ? TW'(NB_MAX) : TW'(r_order_b) + TW'(1);
    end

    // Circular history addresses: the current sample sits at r_uwp.
    always_comb begin
        w_upos  = (UW+2)'(w_k) + (UW+2)'(r_cnt);
        w_usum  = (UW+2)'(r_uwp) + (UW+2)'(UH) - w_upos;
        w_uh_ra = (w_usum >= (UW+2)'(UH)) ? UW'(w_usum - (UW+2)'(UH)) : UW'(w_usum);
        w_ysum  = (YW+1)'(r_ywp) + (YW+1)'(NA_MAX - 1) - (YW+1)'(r_cnt);
        w_yh_ra = (w_ysum >= (YW+1)'(NA_MAX)) ? YW'(w_ysum - (YW+1)'(NA_MAX)) : YW'(w_ysum);
    end

    // Bank A occupies the low coefficient addresses, bank B follows it.
    always_comb begin
        w_in_ok = w_in.coef_bank ? (32'(w_in.coef_index) < NB_MAX)
                                 : (32'(w_in.coef_index) < NA_MAX);
        w_in_ca = w_in.coef_bank ? CW'(NA_MAX) + CW'(w_in.coef_index)
                                 : CW'(w_in.coef_index);
        case (r_state)
            S_TAP:   w_c_ra = r_ph_a ? r_cnt : CW'(NA_MAX) + r_cnt;
            S_SWEEP: w_c_ra = r_cnt;
            default: w_c_ra = w_in_ca;
        endcase
    end

    assign w_act_val = r_act_qv ? r_act_q : 32'sd0;
    assign w_st_val  = r_st_qv  ? r_st_q  : 32'sd0;
    assign w_dl_val  = r_dl_qv  ? r_dl_q  : 32'sd0;
    assign w_uh_val  = r_uh_qv  ? r_uh_q  : 32'sd0;
    assign w_yh_val  = r_yh_qv  ? r_yh_q  : 32'sd0;

    // Ramp add with saturation.
    always_comb begin
        w_rsum = {w_act_val[31], w_act_val} + {w_dl_val[31], w_dl_val};
        if (w_rsum[32] != w_rsum[31]) begin
            w_rsat = w_rsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_rsat = w_rsum[31:0];
        end
    end

    always_comb begin
        w_act_we = 1'b0;
        w_act_wa = r_sw_a;
        w_act_wd = r_sw_ramp ? w_rsat : w_st_val;
        if (r_sw_v) begin
            w_act_we = 1'b1;
        end else if (w_in_fire && w_in.cmd == CMD_LOAD_START && w_in_ok) begin
            w_act_we = 1'b1;
            w_act_wa = w_in_ca;
            w_act_wd = w_in.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_act_we) begin
            m_act[w_act_wa] <= w_act_wd;
        end
        if (w_in_fire && w_in.cmd == CMD_LOAD_START && w_in_ok) begin
            m_st[w_in_ca] <= w_in.coef_value;
        end
        if (r_state == S_DIV && w_div_stat.done) begin
            m_dl[r_ca] <= w_div_q;
        end
        if (w_in_fire && w_in.cmd == CMD_STEP) begin
            m_uh[r_uwp] <= w_in.sample_in;
        end
        if (w_out_load) begin
            m_yh[r_ywp] <= w_y;
        end
        r_act_q  <= m_act[w_c_ra];
        r_act_qv <= r_act_v[w_c_ra];
        r_st_q   <= m_st[w_c_ra];
        r_st_qv  <= r_st_v[w_c_ra];
        r_dl_q   <= m_dl[w_c_ra];
        r_dl_qv  <= r_dl_v[w_c_ra];
        r_uh_q   <= m_uh[w_uh_ra];
        r_uh_qv  <= r_uh_v[w_uh_ra];
        r_yh_q   <= m_yh[w_yh_ra];
        r_yh_qv  <= r_yh_v[w_yh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_v <= '0;
            r_st_v  <= '0;
            r_dl_v  <= '0;
            r_uh_v  <= '0;
            r_yh_v  <= '0;
        end else begin
            if (w_act_we) begin
                r_act_v[w_act_wa] <= 1'b1;
            end
            if (w_in_fire && w_in.cmd == CMD_LOAD_START && w_in_ok) begin
                r_st_v[w_in_ca] <= 1'b1;
            end
            if (r_state == S_DIV && w_div_stat.done) begin
                r_dl_v[r_ca] <= 1'b1;
            end
            if (w_in_fire && w_in.cmd == CMD_STEP) begin
                r_uh_v[r_uwp] <= 1'b1;
            end
            if (w_out_load) begin
                r_yh_v[r_ywp] <= 1'b1;
            end
        end
    end

    // Round to Q16.16 and saturate.
    always_comb begin
        w_rnd = r_acc + 64'sd524288;
        w_sh  = w_rnd >>> 20;
        w_ovf = !((&w_sh[63:31]) || !(|w_sh[63:31]));
        if (w_ovf) begin
            w_y = w_sh[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_y = w_sh[31:0];
        end
        w_term = r_prod >>> 8;
    end

    assign w_tap_last = r_ph_a ? (TW'(r_cnt) == w_na - TW'(1))
                               : (TW'(r_cnt) == w_nb - TW'(1));
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    assign w_period    = (r_ramp_period == 16'd0) ? 16'd1 : r_ramp_period;
    assign w_div_start = (r_state == S_DIVRD);
    assign w_div_diff  = {r_cval[31], r_cval} - {w_st_val[31], w_st_val};

    arxm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_diff   (w_div_diff),
        .i_period (w_period),
        .o_stat   (w_div_stat),
        .o_q      (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    case (w_in.cmd)
                        CMD_STEP:        n_state = S_TAP;
                        CMD_LOAD_TARGET: n_state = w_in_ok ? S_DIVRD : S_IDLE;
                        CMD_RAMP:        n_state = S_SWEEP;
                        CMD_RESTORE:     n_state = S_SWEEP;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_TAP: begin
                if (w_tap_last && (r_ph_a || w_na == TW'(0))) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            S_DIVRD: n_state = S_DIV;
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (r_cnt == CW'(NC - 1)) begin
                    n_state = S_SWEND;
                end
            end
            S_SWEND: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers of the tap walk, sweeps and output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_sw_v   <= 1'b0;
            r_ovalid <= 1'b0;
            r_uwp    <= '0;
            r_ywp    <= '0;
            r_cnt    <= '0;
            r_ph_a   <= 1'b0;
        end else begin
            r_p1_v <= (r_state == S_TAP);
            r_p2_v <= r_p1_v;
            r_sw_v <= (r_state == S_SWEEP);
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_uwp    <= (32'(r_uwp) == UH - 1) ? '0 : r_uwp + UW'(1);
                r_ywp    <= (32'(r_ywp) == NA_MAX - 1) ? '0 : r_ywp + YW'(1);
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_in_fire) begin
                r_cnt  <= '0;
                r_ph_a <= 1'b0;
            end else if (r_state == S_TAP) begin
                if (w_tap_last) begin
                    r_cnt  <= '0;
                    r_ph_a <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end else if (r_state == S_SWEEP) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Datapath registers: multiply, accumulate, request capture.
    always_ff @(posedge i_clk) begin
        r_p1_neg <= r_ph_a;
        r_p2_neg <= r_p1_neg;
        r_sw_a   <= r_cnt;
        if (r_p1_v) begin
            r_prod <= w_act_val * (r_p1_neg ? w_yh_val : w_uh_val);
        end
        if (w_in_fire) begin
            r_acc     <= -(64'(w_in.noise_in) <<< 20);
            r_cval    <= w_in.coef_value;
            r_ca      <= w_in_ca;
            r_sw_ramp <= (w_in.cmd == CMD_RAMP);
        end else if (r_p2_v) begin
            r_acc <= r_p2_neg ? r_acc - w_term : r_acc + w_term;
        end
        if (w_out_load) begin
            r_odata.y_out     <= w_y;
            r_odata.saturated <= w_ovf;
        end
    end

    `ARXM_AST_IMP(a_mac_in_step, i_clk, i_rst_n, r_p2_v, r_state == S_TAP || r_state == S_DRAIN)
    `ARXM_AST_IMP(a_out_after_drain, i_clk, i_rst_n, r_state == S_OUT, !r_p1_v && !r_p2_v)
    `ARXM_AST_IMP(a_div_done_waited, i_clk, i_rst_n, w_div_stat.done, r_state == S_DIV)
    `ARXM_AST_NXT(a_sweep_ends, i_clk, i_rst_n, r_state == S_SWEND, !r_sw_v)
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the ARX process model with coefficient ramping.
`timescale 1ns / 1ps
module tb;
    import arxm_pkg::*;

    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam logic BANK_A = 1'b0;
    localparam logic BANK_B = 1'b1;
    localparam int N_TAPS = 8;
    localparam int U_DEPTH = 24;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 240;

    logic i_clk;
    logic i_rst_n;

    arxm_stream_if #(.T(t_in_item))  in_ch ();
    arxm_stream_if #(.T(t_out_item)) out_ch ();
    arxm_stream_if #(.T(t_cfg_req))  cfg_ch ();

    arx_model_step_with_coef_ramp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Model state kept by the testbench.
    logic [4:0]         m_delay;
    logic [3:0]         m_order_a;
    logic [2:0]         m_order_b;
    logic [15:0]        m_period;
    logic signed [31:0] u_line [U_DEPTH];
    logic signed [31:0] y_line [N_TAPS];
    logic signed [31:0] a_act [N_TAPS], a_start [N_TAPS], a_inc [N_TAPS];
    logic signed [31:0] b_act [N_TAPS], b_start [N_TAPS], b_inc [N_TAPS];

    t_out_item y_pending [$];
    int        n_errors = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] clip32(longint v, output logic clipped);
        clipped = 1'b0;
        if (v > longint'(32'sh7fffffff)) begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -longint'(64'sh80000000)) begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] ramp_increment(logic signed [31:0] target,
                                                          logic signed [31:0] from);
        longint per;
        logic   c;
        per = (m_period == 16'd0) ? 1 : longint'({48'd0, m_period});
        return clip32((longint'(target) - longint'(from)) / per, c);
    endfunction

    function automatic logic signed [31:0] ramp_add(logic signed [31:0] c,
                                                    logic signed [31:0] d);
        logic x;
        return clip32(longint'(c) + longint'(d), x);
    endfunction

    // Applies one request to the model; returns 1 when it yields an output sample.
    function automatic bit model_apply(t_in_item it, output t_out_item r);
        int     k, na, nb;
        longint acc;
        logic   clipped;
        r = '0;
        case (it.cmd)
            CMD_STEP: begin
                k  = (m_delay > 16) ? 16 : int'(m_delay);
                na = (m_order_a > N_TAPS) ? N_TAPS : int'(m_order_a);
                nb = int'(m_order_b) + 1;
                for (int i = U_DEPTH - 1; i > 0; i--) u_line[i] = u_line[i-1];
                u_line[0] = it.sample_in;
                acc = 0;
                for (int i = 0; i < nb; i++)
                    if (k + i < U_DEPTH)
                        acc += (longint'(b_act[i]) * longint'(u_line[k+i])) >>> 8;
                for (int i = 0; i < na; i++)
                    acc -= (longint'(a_act[i]) * longint'(y_line[i])) >>> 8;
                acc -= longint'(it.noise_in) * (longint'(1) << 20);
                acc = (acc + (longint'(1) << 19)) >>> 20;
                r.y_out = clip32(acc, clipped);
                r.saturated = clipped;
                for (int i = N_TAPS - 1; i > 0; i--) y_line[i] = y_line[i-1];
                y_line[0] = r.y_out;
                return 1'b1;
            end
            CMD_LOAD_START: begin
                if (it.coef_bank == BANK_A) begin
                    a_act[it.coef_index]   = it.coef_value;
                    a_start[it.coef_index] = it.coef_value;
                end else begin
                    b_act[it.coef_index]   = it.coef_value;
                    b_start[it.coef_index] = it.coef_value;
                end
            end
            CMD_LOAD_TARGET: begin
                if (it.coef_bank == BANK_A)
                    a_inc[it.coef_index] = ramp_increment(it.coef_value, a_start[it.coef_index]);
                else
                    b_inc[it.coef_index] = ramp_increment(it.coef_value, b_start[it.coef_index]);
            end
            CMD_RAMP: begin
                for (int i = 0; i < N_TAPS; i++) begin
                    a_act[i] = ramp_add(a_act[i], a_inc[i]);
                    b_act[i] = ramp_add(b_act[i], b_inc[i]);
                end
            end
            CMD_RESTORE: begin
                for (int i = 0; i < N_TAPS; i++) begin
                    a_act[i] = a_start[i];
                    b_act[i] = b_start[i];
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_in_item make_req(logic [2:0] cmd, logic [31:0] s, logic [31:0] n,
                                          logic bank, logic [2:0] idx, logic [31:0] v);
        t_in_item it;
        it.cmd = cmd;
        it.sample_in = s;
        it.noise_in = n;
        it.coef_bank = bank;
        it.coef_index = idx;
        it.coef_value = v;
        return it;
    endfunction

    // Sends one request; a typed expectation, if given, replaces the model's output.
    task automatic send_req(t_in_item it, bit typed, t_out_item typed_y);
        t_out_item r;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (model_apply(it, r))
            y_pending.insert(y_pending.size(), typed ? typed_y : r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    // Leaves valid high so that writes can follow back to back; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        t_cfg_req c;
        c.idx = idx;
        c.data = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_DELAY_K:     m_delay   = value[4:0];
            CFG_ORDER_A:     m_order_a = value[3:0];
            CFG_ORDER_B:     m_order_b = value[2:0];
            CFG_RAMP_PERIOD: m_period  = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (y_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_signal();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(134217728)) - 67108864);
        endcase
    endfunction

    function automatic t_in_item rand_req();
        int       w;
        logic [2:0] cmd;
        w = $urandom_range(99);
        if (w < 60)      cmd = CMD_STEP;
        else if (w < 73) cmd = CMD_LOAD_START;
        else if (w < 84) cmd = CMD_LOAD_TARGET;
        else if (w < 91) cmd = CMD_RAMP;
        else if (w < 95) cmd = CMD_RESTORE;
        else             cmd = 3'($urandom_range(7, 5));
        return make_req(cmd, rand_signal(), ($urandom_range(3) == 0) ? $urandom() : rand_signal() >>> 4,
                        1'($urandom_range(1)), 3'($urandom_range(7)), rand_coef());
    endfunction

    // Output side: random back-pressure and in-order comparison.
    always @(posedge i_clk) begin
        t_out_item want;
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (y_pending.size() == 0) begin
                $error("unexpected output sample y_out=%0d", $signed(out_ch.data.y_out));
                n_errors++;
            end else begin
                want = y_pending.pop_front();
                if (out_ch.data.y_out !== want.y_out) begin
                    $error("y_out: expected %0d, got %0d", $signed(want.y_out),
                           $signed(out_ch.data.y_out));
                    n_errors++;
                end
                if (out_ch.data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated,
                           out_ch.data.saturated);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_in_item  rows [$];
        t_out_item row_y [$];
        bit        row_typed [$];
        t_out_item none;
        logic [15:0] phase_cfg [N_PHASES][4];

        phase_cfg = '{'{16'd3, 16'd2, 16'd1, 16'd4},
                      '{16'd16, 16'd8, 16'd7, 16'd65535},
                      '{16'd31, 16'd15, 16'd7, 16'd0},
                      '{16'd0, 16'd0, 16'd0, 16'd1},
                      '{16'd5, 16'd4, 16'd3, 16'd100},
                      '{16'd17, 16'd9, 16'd2, 16'd7},
                      '{16'd1, 16'd8, 16'd7, 16'd3},
                      '{16'd0, 16'd1, 16'd0, 16'hffe0}};
        none = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        m_delay = 5'd0;
        m_order_a = 4'd1;
        m_order_b = 3'd0;
        m_period = 16'd1;
        for (int i = 0; i < U_DEPTH; i++) u_line[i] = '0;
        for (int i = 0; i < N_TAPS; i++) begin
            y_line[i] = '0;
            a_act[i] = '0; a_start[i] = '0; a_inc[i] = '0;
            b_act[i] = '0; b_start[i] = '0; b_inc[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: with zero coefficients the output is just the negated, saturated noise.
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h7fffffff, 32'h0, BANK_A, 3'd0, 32'h0));
        row_typed.insert(row_typed.size(), 1);
        row_y.insert(row_y.size(), t_out_item'{32'h0, 1'b0});
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h80000000, 32'h1, BANK_A, 3'd0, 32'h0));
        row_typed.insert(row_typed.size(), 1);
        row_y.insert(row_y.size(), t_out_item'{32'hffffffff, 1'b0});
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h0, 32'h80000000, BANK_A, 3'd0, 32'h0));
        row_typed.insert(row_typed.size(), 1);
        row_y.insert(row_y.size(), t_out_item'{32'h7fffffff, 1'b1});
        rows.insert(rows.size(), make_req(CMD_STEP, 32'hffffffff, 32'h7fffffff, BANK_B, 3'd7,
                                          32'h0));
        row_typed.insert(row_typed.size(), 1);
        row_y.insert(row_y.size(), t_out_item'{32'h80000001, 1'b0});
        rows.insert(rows.size(), make_req(CMD_LOAD_START, 32'h0, 32'h0, BANK_A, 3'd0,
                                          32'h10000000));
        rows.insert(rows.size(), make_req(CMD_LOAD_START, 32'h0, 32'h0, BANK_B, 3'd0,
                                          32'h10000000));
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h00010000, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_LOAD_START, 32'h0, 32'h0, BANK_B, 3'd7,
                                          32'h80000000));
        rows.insert(rows.size(), make_req(CMD_LOAD_START, 32'h0, 32'h0, BANK_A, 3'd7,
                                          32'h7fffffff));
        // A target far from its start overflows the increment at a period of one.
        rows.insert(rows.size(), make_req(CMD_LOAD_TARGET, 32'h0, 32'h0, BANK_A, 3'd0,
                                          32'h80000000));
        rows.insert(rows.size(), make_req(CMD_LOAD_TARGET, 32'h0, 32'h0, BANK_B, 3'd0,
                                          32'h7fffffff));
        rows.insert(rows.size(), make_req(CMD_LOAD_TARGET, 32'h0, 32'h0, BANK_A, 3'd7,
                                          32'h7fffffff));
        rows.insert(rows.size(), make_req(CMD_LOAD_START, 32'h0, 32'h0, BANK_A, 3'd0,
                                          32'h08000000));
        rows.insert(rows.size(), make_req(CMD_RAMP, 32'h0, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_RAMP, 32'h0, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h7fffffff, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_RESTORE, 32'h0, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h80000000, 32'hffff0000, BANK_A, 3'd0,
                                          32'h0));
        rows.insert(rows.size(), make_req(CMD_SPARE5, 32'h0, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_SPARE6, 32'hffffffff, 32'hffffffff, BANK_B, 3'd7,
                                          32'hffffffff));
        rows.insert(rows.size(), make_req(CMD_SPARE7, 32'h0, 32'h0, BANK_A, 3'd0, 32'h0));
        rows.insert(rows.size(), make_req(CMD_STEP, 32'h00008000, 32'h00000001, BANK_A, 3'd0,
                                          32'h0));
        for (int i = row_typed.size(); i < rows.size(); i++) begin
            row_typed.insert(row_typed.size(), 0);
            row_y.insert(row_y.size(), none);
        end
        foreach (rows[i]) send_req(rows[i], row_typed[i], row_y[i]);
        wait_idle();

        // Random part, one register setting and one idling pattern per phase.
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_DELAY_K, phase_cfg[p][0]);
            write_reg(CFG_ORDER_A, phase_cfg[p][1]);
            write_reg(CFG_ORDER_B, phase_cfg[p][2]);
            write_reg(CFG_RAMP_PERIOD, phase_cfg[p][3]);
            cfg_ch.valid <= 1'b0;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(rand_req(), 0, none);
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
